// File: sv/int2rd_pkg.sv
// shared constants, types and digit encoding for the radix digit converter
`timescale 1ns / 1ps

package int2rd_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int CNT_W       = $clog2(VALUE_WIDTH);
  localparam int STORE_DEPTH = 64;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int COUNT_W     = STORE_AW + 1;
  localparam int RADIX_W     = 6;
  localparam int CHAR_W      = 7;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] DIGIT_TEN   = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_A      = 7'd65;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic start;
    logic load;
  } div_ctrl_t;

  typedef struct packed {
    logic               done;
    logic               quot_zero;
    logic [RADIX_W-1:0] rem;
  } div_stat_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + {1'b0, d};
    end else begin
      c = CHAR_A + {1'b0, d} - {1'b0, DIGIT_TEN};
    end
    return c;
  endfunction

endpackage

// File: sv/int2rd_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module int2rd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/int2rd_div.sv
// bit-serial restoring divider by the radix, one quotient bit per cycle
`timescale 1ns / 1ps

module int2rd_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  int2rd_pkg::div_ctrl_t                ctrl_i,
  input  logic [int2rd_pkg::VALUE_WIDTH-1:0]   value_i,
  input  logic [int2rd_pkg::RADIX_W-1:0]       base_i,
  output int2rd_pkg::div_stat_t                stat_o
);

  localparam logic [int2rd_pkg::CNT_W-1:0] LastBit =
    int2rd_pkg::CNT_W'(int2rd_pkg::VALUE_WIDTH - 1);

  logic [int2rd_pkg::VALUE_WIDTH-1:0] quot_q, quot_d;
  logic [int2rd_pkg::RADIX_W-1:0]     rem_q, rem_d;
  logic [int2rd_pkg::CNT_W-1:0]       cnt_q;
  logic                               busy_q;
  logic                               done_q;
  logic [int2rd_pkg::RADIX_W:0]       trial;
  logic [int2rd_pkg::RADIX_W:0]       base_ext;
  logic                               ge;

  assign trial    = {rem_q, quot_q[int2rd_pkg::VALUE_WIDTH-1]};
  assign base_ext = {1'b0, base_i};
  assign ge       = trial >= base_ext;

  always_comb begin
    rem_d  = ge ? int2rd_pkg::RADIX_W'(trial - base_ext) : trial[int2rd_pkg::RADIX_W-1:0];
    quot_d = {quot_q[int2rd_pkg::VALUE_WIDTH-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LastBit);
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastBit) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // payload shift registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rem_q <= '0;
      if (ctrl_i.load) begin
        quot_q <= value_i;
      end
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign stat_o.done      = done_q;
  assign stat_o.quot_zero = (quot_q == '0);
  assign stat_o.rem       = rem_q;

endmodule

// File: sv/integer_to_radix_digits.sv
// top level: unsigned integer to ascii digits in a configurable radix
`timescale 1ns / 1ps

// Converts one unsigned integer per input transaction into its ASCII digits in the radix
// held by the configuration register (written values below 2 act as 2, above 36 as 36),
// most significant digit first, one output transaction per character, tlast on the final
// one; zero gives the single character '0'. Each digit comes from a bit-serial division
// that shifts the value through the divider one bit per cycle, and each character is
// then read from the remainder ram through its registered read port and loaded into the
// output register, which waits while the output register still holds an unaccepted
// character. A new item is taken while the last character still waits on the output.

module integer_to_radix_digits (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,     // radix
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,    // number_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,    // digit_char, zero pad bit
  output logic        m_axis_tlast     // last_digit
);

  int2rd_pkg::state_e                  state_q, state_d;
  logic [int2rd_pkg::RADIX_W-1:0]      radix_q;
  logic [int2rd_pkg::RADIX_W-1:0]      base;
  logic [int2rd_pkg::COUNT_W-1:0]      count_q, count_d;
  logic [int2rd_pkg::STORE_AW-1:0]     ptr_q, ptr_d;
  int2rd_pkg::div_ctrl_t               div_ctrl;
  int2rd_pkg::div_stat_t               div_stat;
  logic                                ram_we;
  logic                                ram_re;
  logic [int2rd_pkg::RADIX_W-1:0]      ram_rdata;
  logic                                out_free;
  logic                                out_load;
  logic                                m_valid_q;
  logic [int2rd_pkg::CHAR_W-1:0]       m_char_q;
  logic                                m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= int2rd_pkg::RADIX_RESET;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (radix_q < int2rd_pkg::RADIX_MIN) begin
      base = int2rd_pkg::RADIX_MIN;
    end else if (radix_q > int2rd_pkg::RADIX_MAX) begin
      base = int2rd_pkg::RADIX_MAX;
    end else begin
      base = radix_q;
    end
  end

  int2rd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (div_ctrl),
    .value_i (s_axis_tdata[int2rd_pkg::VALUE_WIDTH-1:0]),
    .base_i  (base),
    .stat_o  (div_stat)
  );

  int2rd_ram #(
    .WIDTH (int2rd_pkg::RADIX_W),
    .DEPTH (int2rd_pkg::STORE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[int2rd_pkg::STORE_AW-1:0]),
    .wdata_i (div_stat.rem),
    .re_i    (ram_re),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == int2rd_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= int2rd_pkg::ST_IDLE;
      count_q <= '0;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ptr_q   <= ptr_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ptr_d    = ptr_q;
    div_ctrl = '0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      int2rd_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          div_ctrl.start = 1'b1;
          div_ctrl.load  = 1'b1;
          count_d        = '0;
          state_d        = int2rd_pkg::ST_DIV;
        end
      end
      int2rd_pkg::ST_DIV: begin
        if (div_stat.done) begin
          ram_we  = 1'b1;
          count_d = count_q + 1'b1;
          if (div_stat.quot_zero) begin
            ptr_d   = count_q[int2rd_pkg::STORE_AW-1:0];
            state_d = int2rd_pkg::ST_RD;
          end else begin
            div_ctrl.start = 1'b1;
          end
        end
      end
      int2rd_pkg::ST_RD: begin
        ram_re  = 1'b1;
        state_d = int2rd_pkg::ST_LOAD;
      end
      int2rd_pkg::ST_LOAD: begin
        if (out_free) begin
          out_load = 1'b1;
          if (ptr_q == '0) begin
            state_d = int2rd_pkg::ST_IDLE;
          end else begin
            ptr_d   = ptr_q - 1'b1;
            state_d = int2rd_pkg::ST_RD;
          end
        end
      end
      default: begin
        state_d = int2rd_pkg::ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_char_q <= int2rd_pkg::digit_to_char(ram_rdata);
      m_last_q <= (ptr_q == '0);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_char_q};
  assign m_axis_tlast  = m_last_q;

endmodule

// File: sv/int2rd_chk.sv
// port-level checker for the radix digit converter, bound to the top level
`timescale 1ns / 1ps

module int2rd_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata >= 8'd48 && m_axis_tdata <= 8'd57) ||
                      (m_axis_tdata >= 8'd65 && m_axis_tdata <= 8'd90))
    else $error("output is not a digit character");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken during conversion");

endmodule

bind integer_to_radix_digits int2rd_chk u_int2rd_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
